// ----- rtl/hmpq_pkg.sv -----
// ----------------------------------------------------------------------------
// hmpq_pkg
// Shared types and codes of the indexed min-heap priority queue.
// ----------------------------------------------------------------------------
package hmpq_pkg;

    localparam int KEY_W     = 8;
    localparam int COST_W    = 32;
    localparam int KEY_SPACE = 256;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_EXTRACT  = 2'd1;
    localparam logic [OP_W-1:0] OP_DECREASE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP       = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ABSENT    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOT_LOWER = 3'd5;

    // one heap slot
    typedef struct packed {
        logic signed [COST_W-1:0] cost;
        logic [KEY_W-1:0]         key;
    } entry_t;

    // one result
    typedef struct packed {
        logic signed [COST_W-1:0] cost;
        logic [KEY_W-1:0]         key;
        logic [STATUS_W-1:0]      status;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_EXT_ROOT,
        ST_EXT_LAST,
        ST_DN_L,
        ST_DN_LR,
        ST_DN_RR,
        ST_DN_SW,
        ST_DEC_MAP,
        ST_DEC_CMP,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/hmpq_ram.sv -----
// ----------------------------------------------------------------------------
// hmpq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hmpq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/hmpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// hmpq_ctrl
// Operation sequencer: checks, sift up and sift down over the heap RAM,
// position map writes, valid bits and entry count.
// ----------------------------------------------------------------------------
module hmpq_ctrl
    import hmpq_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [OP_W-1:0]              in_op,
    input  logic [KEY_W-1:0]             in_key,
    input  logic signed [COST_W-1:0]     in_cost,
    output logic                         res_valid,
    input  logic                         res_ready,
    output result_t                      res,
    output logic                         heap_we,
    output logic [$clog2(CAPACITY)-1:0]  heap_waddr,
    output entry_t                       heap_wdata,
    output logic [$clog2(CAPACITY)-1:0]  heap_raddr,
    input  entry_t                       heap_rdata,
    output logic                         map_we,
    output logic [KEY_W-1:0]             map_waddr,
    output logic [$clog2(CAPACITY)-1:0]  map_wdata,
    input  logic [$clog2(CAPACITY)-1:0]  map_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [KEY_SPACE-1:0] vld_reg, vld_next;
    logic [AW-1:0]        hole_reg, hole_next;
    logic [AW-1:0]        bidx_reg, bidx_next;
    logic                 bsel_reg, bsel_next;
    entry_t               mov_reg, mov_next;
    entry_t               best_reg, best_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic signed [COST_W-1:0] cost_reg, cost_next;
    result_t              res_reg, res_next;

    logic          key_ok, key_vld, is_full, is_empty;
    logic [AW-1:0] parent;
    logic [IW-1:0] left_idx, right_idx;
    logic          left_in, right_in, up_less, dec_lower, pos_bad;

    // request checks and tree index arithmetic
    assign key_ok    = (int'(in_key) < CAPACITY);
    assign key_vld   = vld_reg[in_key];
    assign is_full   = (cnt_reg == CW'(CAPACITY));
    assign is_empty  = (cnt_reg == '0);
    assign parent    = AW'((hole_reg - AW'(1)) >> 1);
    assign left_idx  = {1'b0, hole_reg, 1'b1};
    assign right_idx = left_idx + IW'(1);
    assign left_in   = (left_idx < IW'(cnt_reg));
    assign right_in  = (right_idx < IW'(cnt_reg));
    assign up_less   = (mov_reg.cost < heap_rdata.cost);
    assign dec_lower = (cost_reg < heap_rdata.cost);
    assign pos_bad   = (CW'(map_rdata) >= cnt_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_INSERT:
                            state_next = (is_full || !key_ok || key_vld) ? ST_DONE : ST_UP_RD;
                        OP_EXTRACT:
                            state_next = is_empty ? ST_DONE : ST_EXT_ROOT;
                        OP_DECREASE:
                            state_next = (!key_ok || !key_vld) ? ST_DONE : ST_DEC_MAP;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_UP_RD:    state_next = (hole_reg == '0) ? ST_DONE : ST_UP_CMP;
            ST_UP_CMP:   state_next = up_less ? ST_UP_RD : ST_DONE;
            ST_EXT_ROOT: state_next = (cnt_reg == CW'(1)) ? ST_DONE : ST_EXT_LAST;
            ST_EXT_LAST: state_next = ST_DN_L;
            ST_DN_L:     state_next = left_in ? ST_DN_LR : ST_DONE;
            ST_DN_LR:    state_next = right_in ? ST_DN_RR : ST_DN_SW;
            ST_DN_RR:    state_next = ST_DN_SW;
            ST_DN_SW:    state_next = bsel_reg ? ST_DN_L : ST_DONE;
            ST_DEC_MAP:  state_next = pos_bad ? ST_DONE : ST_DEC_CMP;
            ST_DEC_CMP:  state_next = dec_lower ? ST_UP_RD : ST_DONE;
            ST_DONE:     state_next = res_ready ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cnt_next   = cnt_reg;
        vld_next   = vld_reg;
        hole_next  = hole_reg;
        bidx_next  = bidx_reg;
        bsel_next  = bsel_reg;
        mov_next   = mov_reg;
        best_next  = best_reg;
        key_next   = key_reg;
        cost_next  = cost_reg;
        res_next   = res_reg;
        heap_we    = 1'b0;
        heap_waddr = hole_reg;
        heap_wdata = mov_reg;
        heap_raddr = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = in_key;
                    cost_next = in_cost;
                    res_next = '0;
                    unique case (in_op)
                        OP_INSERT:
                        begin
                            if (is_full)
                            begin
                                res_next.status = STAT_FULL;
                            end
                            else if (!key_ok)
                            begin
                                res_next.status = STAT_ABSENT;
                            end
                            else if (key_vld)
                            begin
                                res_next.status = STAT_DUP;
                            end
                            else
                            begin
                                vld_next[in_key] = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                                mov_next.key = in_key;
                                mov_next.cost = in_cost;
                                hole_next = AW'(cnt_reg);
                            end
                        end
                        OP_EXTRACT:
                        begin
                            if (is_empty)
                            begin
                                res_next.status = STAT_EMPTY;
                            end
                        end
                        OP_DECREASE:
                        begin
                            if (!key_ok || !key_vld)
                            begin
                                res_next.status = STAT_ABSENT;
                            end
                        end
                        default:
                        begin
                            res_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_UP_RD:
            begin
                // read the parent, or settle at the root
                heap_raddr = parent;
                heap_we = (hole_reg == '0);
            end
            ST_UP_CMP:
            begin
                heap_we = 1'b1;
                if (up_less)
                begin
                    heap_wdata = heap_rdata;
                    hole_next = parent;
                end
            end
            ST_EXT_ROOT:
            begin
                res_next.status = STAT_OK;
                res_next.key = heap_rdata.key;
                res_next.cost = heap_rdata.cost;
                vld_next[heap_rdata.key] = 1'b0;
                cnt_next = cnt_reg - CW'(1);
                heap_raddr = AW'(cnt_reg - CW'(1));
            end
            ST_EXT_LAST:
            begin
                mov_next = heap_rdata;
                hole_next = '0;
            end
            ST_DN_L:
            begin
                heap_raddr = AW'(left_idx);
                heap_we = !left_in;
            end
            ST_DN_LR:
            begin
                heap_raddr = AW'(right_idx);
                if (heap_rdata.cost < mov_reg.cost)
                begin
                    best_next = heap_rdata;
                    bsel_next = 1'b1;
                    bidx_next = AW'(left_idx);
                end
                else
                begin
                    best_next = mov_reg;
                    bsel_next = 1'b0;
                end
            end
            ST_DN_RR:
            begin
                if (heap_rdata.cost < best_reg.cost)
                begin
                    best_next = heap_rdata;
                    bsel_next = 1'b1;
                    bidx_next = AW'(right_idx);
                end
            end
            ST_DN_SW:
            begin
                // move the smaller child up, or drop the entry into the hole
                heap_we = 1'b1;
                if (bsel_reg)
                begin
                    heap_wdata = best_reg;
                    hole_next = bidx_reg;
                end
            end
            ST_DEC_MAP:
            begin
                heap_raddr = map_rdata;
                hole_next = map_rdata;
                if (pos_bad)
                begin
                    res_next.status = STAT_ABSENT;
                end
            end
            ST_DEC_CMP:
            begin
                if (!dec_lower)
                begin
                    res_next.status = STAT_NOT_LOWER;
                end
                else
                begin
                    mov_next.key = key_reg;
                    mov_next.cost = cost_reg;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // every slot write moves an entry, so its map entry follows it
    assign map_we    = heap_we;
    assign map_waddr = heap_wdata.key;
    assign map_wdata = heap_waddr;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            vld_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vld_reg   <= vld_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        hole_reg <= hole_next;
        bidx_reg <= bidx_next;
        bsel_reg <= bsel_next;
        mov_reg  <= mov_next;
        best_reg <= best_next;
        key_reg  <= key_next;
        cost_reg <= cost_next;
        res_reg  <= res_next;
    end

endmodule

// ----- rtl/indexed_min_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_priority_queue
// Binary min-heap of (key, cost) pairs with a key-to-position map.
// ----------------------------------------------------------------------------
// One request at a time: insert, extract-minimum or decrease-cost, each
// giving one result. The heap slots sit in one RAM and the key-to-position
// map in another, both with a registered read; the valid bit of every key is
// a flip-flop cleared at reset, so the block is ready right after reset.
// A request is walked by a sequencer that reads one slot per cycle and
// writes one slot per cycle. Refused requests and the unused code go
// straight to the result; an insert settles at the root or rises level by
// level; a decrease finds its slot through the map and then rises like an
// insert; an extract either empties the heap or moves the last entry to
// the root and sinks it. The sift loop runs over up to log2(CAPACITY)
// levels, with every slot read going through the single heap RAM read port.
// A finished result sits in an output register, so the next request is
// taken while the previous result waits.
// ----------------------------------------------------------------------------
module indexed_min_heap_priority_queue
    import hmpq_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_key [7:0], item_cost [39:8]
    input  logic [1:0]  s_tuser,   // operation [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_key [7:0], out_cost [39:8]
    output logic [2:0]  m_tuser    // status [2:0]
);

    localparam int AW = $clog2(CAPACITY);

    logic          res_valid, res_ready, load;
    result_t       res;
    logic          heap_we;
    logic [AW-1:0] heap_waddr, heap_raddr;
    entry_t        heap_wdata, heap_rdata;
    logic          map_we;
    logic [KEY_W-1:0] map_waddr;
    logic [AW-1:0] map_wdata, map_rdata;

    logic    out_vld_reg, out_vld_next;
    result_t out_res_reg;

    hmpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_key     (s_tdata[7:0]),
        .in_cost    (s_tdata[39:8]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .heap_we    (heap_we),
        .heap_waddr (heap_waddr),
        .heap_wdata (heap_wdata),
        .heap_raddr (heap_raddr),
        .heap_rdata (heap_rdata),
        .map_we     (map_we),
        .map_waddr  (map_waddr),
        .map_wdata  (map_wdata),
        .map_rdata  (map_rdata)
    );

    hmpq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    hmpq_ram #(
        .WIDTH (AW),
        .DEPTH (KEY_SPACE)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (s_tdata[7:0]),
        .rdata (map_rdata)
    );

    // output register: load when empty or being drained
    assign res_ready = !out_vld_reg || m_tready;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (load)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {out_res_reg.cost, out_res_reg.key};

endmodule

// ----- rtl/hmpq_checker.sv -----
// ----------------------------------------------------------------------------
// hmpq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module hmpq_checker
    import hmpq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // one request in flight: ready drops after an accept
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    // only a successful extract carries a key and cost
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("nonzero payload on a refused request");

    // status code in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= STAT_NOT_LOWER))
        else $error("undefined status code");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind indexed_min_heap_priority_queue hmpq_checker u_hmpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- dv/indexed_min_heap_priority_queue_test.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_priority_queue_test
// Self-checking bench for the indexed min-heap priority queue.
// ----------------------------------------------------------------------------
// Drives insert, extract-minimum and decrease-cost requests (plus the unused
// operation code) with random gaps on both sides, keeps its own heap with a
// key-to-slot map to predict each result, and compares every result in order.
// ----------------------------------------------------------------------------
module indexed_min_heap_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hmpq_pkg::*;

    localparam int SLOTS = 256;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [COST_W-1:0]   cost;
    } outcome_t;

    // ------------------------------------------------------------------------
    // Heap tracker and result scoreboard
    // ------------------------------------------------------------------------
    class heap_scoreboard;
        logic [KEY_W-1:0]         slot_key [SLOTS];
        logic signed [COST_W-1:0] slot_cost [SLOTS];
        int unsigned              slot_of [KEY_SPACE];
        bit                       present [KEY_SPACE];
        int unsigned              count;
        outcome_t                 pending [$];
        int                       errors;

        function void clear();
            count = 0;
            errors = 0;
            pending.delete();
            foreach (present[k])
                present[k] = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic [KEY_W-1:0]         tk;
            logic signed [COST_W-1:0] tc;
            tk = slot_key[a];
            tc = slot_cost[a];
            slot_key[a] = slot_key[b];
            slot_cost[a] = slot_cost[b];
            slot_key[b] = tk;
            slot_cost[b] = tc;
            slot_of[slot_key[a]] = a;
            slot_of[slot_key[b]] = b;
        endfunction

        function void rise(int unsigned i);
            int unsigned up;
            while (i > 0)
            begin
                up = (i - 1) / 2;
                if (!(slot_cost[i] < slot_cost[up]))
                    break;
                swap_slots(i, up);
                i = up;
            end
        endfunction

        function void sink(int unsigned i);
            int unsigned lc, rc, best;
            forever
            begin
                lc = 2 * i + 1;
                rc = 2 * i + 2;
                best = i;
                if (lc < count && slot_cost[lc] < slot_cost[best])
                    best = lc;
                if (rc < count && slot_cost[rc] < slot_cost[best])
                    best = rc;
                if (best == i)
                    break;
                swap_slots(i, best);
                i = best;
            end
        endfunction

        // apply one accepted request and queue its expected result
        function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                   logic signed [COST_W-1:0] cost);
            outcome_t r;
            r = '0;
            r.status = STAT_OK;
            case (op)
                OP_INSERT:
                begin
                    if (count >= SLOTS)
                        r.status = STAT_FULL;
                    else if (present[key])
                        r.status = STAT_DUP;
                    else
                    begin
                        slot_key[count] = key;
                        slot_cost[count] = cost;
                        slot_of[key] = count;
                        present[key] = 1;
                        count++;
                        rise(count - 1);
                    end
                end
                OP_EXTRACT:
                begin
                    if (count == 0)
                        r.status = STAT_EMPTY;
                    else
                    begin
                        r.key = slot_key[0];
                        r.cost = slot_cost[0];
                        present[slot_key[0]] = 0;
                        count--;
                        if (count > 0)
                        begin
                            slot_key[0] = slot_key[count];
                            slot_cost[0] = slot_cost[count];
                            slot_of[slot_key[0]] = 0;
                            sink(0);
                        end
                    end
                end
                OP_DECREASE:
                begin
                    if (!present[key])
                        r.status = STAT_ABSENT;
                    else if (!(cost < slot_cost[slot_of[key]]))
                        r.status = STAT_NOT_LOWER;
                    else
                    begin
                        slot_cost[slot_of[key]] = cost;
                        rise(slot_of[key]);
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        task report(string what, logic [39:0] got, logic [39:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // compare one result with the oldest expectation
        task check_result(logic [2:0] status, logic [39:0] data);
            outcome_t e;
            if (pending.size() == 0)
            begin
                report("unexpected result", data, '0);
                return;
            end
            e = pending.pop_front();
            if (status !== e.status)
                report("status", status, e.status);
            if (data[7:0] !== e.key)
                report("out_key", data[7:0], e.key);
            if (data[39:8] !== e.cost)
                report("out_cost", data[39:8], e.cost);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    heap_scoreboard heap_model;
    bit             calm;

    indexed_min_heap_priority_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // free-running clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // hard stop for a hung run
    initial
    begin
        #8ms;
        $display("FAIL");
        $finish;
    end

    // drive one request with an optional gap before it; valid stays high
    // after an accept until the next request or the end of stimulus
    task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                logic signed [COST_W-1:0] cost);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {cost, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        heap_model.note_request(op, key, cost);
    endtask

    // random key biased toward a small pool so duplicates and hits are common
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 3) != 0)
            return KEY_W'($urandom_range(0, 47));
        return KEY_W'($urandom_range(0, 255));
    endfunction

    function automatic logic signed [COST_W-1:0] pick_cost();
        case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $signed($urandom_range(0, 40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    // result side: random stalls, check each accepted result
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17))
                    @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
                heap_model.check_result(m_tuser, m_tdata);
        end
    end

    // stimulus
    initial
    begin
        int op_pick;
        heap_model = new();
        heap_model.clear();
        calm = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_INSERT;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, unused code, absent, extremes, ties, not lower
        send_request(OP_EXTRACT, 8'd0, 0);
        send_request(OP_DECREASE, 8'd5, 0);
        send_request(OP_UNUSED, 8'hFF, 32'shFFFF_FFFF);
        send_request(OP_INSERT, 8'd255, 32'sh7FFF_FFFF);
        send_request(OP_INSERT, 8'd0, 32'sh8000_0000);
        send_request(OP_INSERT, 8'd0, 5);
        send_request(OP_INSERT, 8'd7, 10);
        send_request(OP_INSERT, 8'd8, 10);
        send_request(OP_INSERT, 8'd9, 10);
        send_request(OP_DECREASE, 8'd9, 10);
        send_request(OP_DECREASE, 8'd9, 11);
        send_request(OP_DECREASE, 8'd255, 32'sh8000_0000);
        send_request(OP_DECREASE, 8'd255, -1);
        repeat (7)
            send_request(OP_EXTRACT, 8'hAA, 32'sh5555_5555);

        // fill to capacity, then try one more
        for (int k = 0; k < SLOTS; k++)
            send_request(OP_INSERT, k[7:0], $urandom);
        send_request(OP_INSERT, 8'd3, 1);
        send_request(OP_DECREASE, 8'd200, 32'sh8000_0000);
        for (int k = 0; k < 40; k++)
            send_request(OP_EXTRACT, 8'd0, 0);

        // random mix, last stretch without gaps
        for (int n = 0; n < 180; n++)
        begin
            if (n == 150)
                calm = 1;
            op_pick = $urandom_range(0, 19);
            if (op_pick < 8)
                send_request(OP_INSERT, pick_key(), pick_cost());
            else if (op_pick < 13)
                send_request(OP_EXTRACT, pick_key(), pick_cost());
            else if (op_pick < 19)
                send_request(OP_DECREASE, pick_key(), pick_cost());
            else
                send_request(OP_UNUSED, pick_key(), pick_cost());
        end
        // drain the heap
        for (int k = 0; k < 300 && heap_model.count > 0; k++)
            send_request(OP_EXTRACT, 8'd0, 0);
        s_tvalid <= 1'b0;

        while (heap_model.pending.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        if (heap_model.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
